### src/rtos_latency_watchdog_assert.svh
// Assertion macros for the scheduler latency watchdog
`ifndef RTOS_LATENCY_WATCHDOG_ASSERT_SVH
`define RTOS_LATENCY_WATCHDOG_ASSERT_SVH

// Check a consequence in the same cycle
`define RLW_ASSERT_HOLDS(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("rtos_latency_watchdog: same-cycle check failed");

// Check a consequence in the following cycle
`define RLW_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("rtos_latency_watchdog: next-cycle check failed");

`endif

### src/rlw_pkg.sv
// Shared types and constants of the scheduler latency watchdog
`default_nettype none

package rlw_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int TS_W              = 32;
  localparam int THRESH_W          = 32;
  localparam int DEPTH_W           = 16;
  localparam int OP_W              = 3;
  localparam int RPT_W             = 2;
  localparam int LEVEL_W           = 2;
  localparam int CFG_ADDR_W        = 5;
  localparam int CFG_DATA_W        = 32;
  localparam int REG_IDX_W         = CFG_ADDR_W - 2;

  typedef enum logic [OP_W-1:0] {
    OP_INIT      = 3'd0,
    OP_TASK_IN   = 3'd1,
    OP_TASK_OUT  = 3'd2,
    OP_IRQ_BEGIN = 3'd3,
    OP_IRQ_END   = 3'd4
  } rlw_op_t;

  typedef enum logic [RPT_W-1:0] {
    RPT_NONE  = 2'd0,
    RPT_WARN  = 2'd1,
    RPT_ERROR = 2'd2
  } rlw_rpt_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IRQ_OFF_WARN   = 3'd0,
    REG_IRQ_OFF_ERROR  = 3'd1,
    REG_TASK_RUN_WARN  = 3'd2,
    REG_TASK_RUN_ERROR = 3'd3,
    REG_IDLE_GAP_WARN  = 3'd4,
    REG_IDLE_GAP_ERROR = 3'd5
  } rlw_reg_t;

  typedef struct packed {
    logic [THRESH_W-1:0] irq_off_warn_ticks;
    logic [THRESH_W-1:0] irq_off_error_ticks;
    logic [THRESH_W-1:0] task_run_warn_ticks;
    logic [THRESH_W-1:0] task_run_error_ticks;
    logic [THRESH_W-1:0] idle_gap_warn_ticks;
    logic [THRESH_W-1:0] idle_gap_error_ticks;
    logic                active;
  } rlw_cfg_t;

endpackage

`default_nettype wire

### src/rlw_if.sv
// Event and report stream interfaces of the scheduler latency watchdog
`default_nettype none

interface rlw_evt_if;
  logic                      valid;
  logic                      ready;
  logic [rlw_pkg::OP_W-1:0]  op;
  logic [rlw_pkg::TS_W-1:0]  timestamp;
  logic                      is_idle;
  logic                      caller_known;
  logic                      restores_enable;

  modport source (
    output valid, op, timestamp, is_idle, caller_known, restores_enable,
    input  ready
  );
  modport sink (
    input  valid, op, timestamp, is_idle, caller_known, restores_enable,
    output ready
  );
endinterface

interface rlw_rpt_if;
  logic                      valid;
  logic                      ready;
  logic [rlw_pkg::RPT_W-1:0] task_run_report;
  logic [rlw_pkg::RPT_W-1:0] idle_starve_report;
  logic [rlw_pkg::RPT_W-1:0] irq_off_report;
  logic                      monitor_active;

  modport source (
    output valid, task_run_report, idle_starve_report, irq_off_report, monitor_active,
    input  ready
  );
  modport sink (
    input  valid, task_run_report, idle_starve_report, irq_off_report, monitor_active,
    output ready
  );
endinterface

`default_nettype wire

### src/rlw_cfg_regs.sv
// APB threshold register file of the scheduler latency watchdog
`default_nettype none

module rlw_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rlw_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rlw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rlw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output rlw_pkg::rlw_cfg_t                   cfg
);

  logic [rlw_pkg::THRESH_W-1:0]  irq_off_warn_ticks;
  logic [rlw_pkg::THRESH_W-1:0]  irq_off_error_ticks;
  logic [rlw_pkg::THRESH_W-1:0]  task_run_warn_ticks;
  logic [rlw_pkg::THRESH_W-1:0]  task_run_error_ticks;
  logic [rlw_pkg::THRESH_W-1:0]  idle_gap_warn_ticks;
  logic [rlw_pkg::THRESH_W-1:0]  idle_gap_error_ticks;
  logic [rlw_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rlw_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_off_warn_ticks   <= '0;
      irq_off_error_ticks  <= '0;
      task_run_warn_ticks  <= '0;
      task_run_error_ticks <= '0;
      idle_gap_warn_ticks  <= '0;
      idle_gap_error_ticks <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rlw_pkg::REG_IRQ_OFF_WARN:   irq_off_warn_ticks   <= pwdata;
        rlw_pkg::REG_IRQ_OFF_ERROR:  irq_off_error_ticks  <= pwdata;
        rlw_pkg::REG_TASK_RUN_WARN:  task_run_warn_ticks  <= pwdata;
        rlw_pkg::REG_TASK_RUN_ERROR: task_run_error_ticks <= pwdata;
        rlw_pkg::REG_IDLE_GAP_WARN:  idle_gap_warn_ticks  <= pwdata;
        rlw_pkg::REG_IDLE_GAP_ERROR: idle_gap_error_ticks <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rlw_pkg::REG_IRQ_OFF_WARN:   prdata = irq_off_warn_ticks;
      rlw_pkg::REG_IRQ_OFF_ERROR:  prdata = irq_off_error_ticks;
      rlw_pkg::REG_TASK_RUN_WARN:  prdata = task_run_warn_ticks;
      rlw_pkg::REG_TASK_RUN_ERROR: prdata = task_run_error_ticks;
      rlw_pkg::REG_IDLE_GAP_WARN:  prdata = idle_gap_warn_ticks;
      rlw_pkg::REG_IDLE_GAP_ERROR: prdata = idle_gap_error_ticks;
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.irq_off_warn_ticks   = irq_off_warn_ticks;
    cfg.irq_off_error_ticks  = irq_off_error_ticks;
    cfg.task_run_warn_ticks  = task_run_warn_ticks;
    cfg.task_run_error_ticks = task_run_error_ticks;
    cfg.idle_gap_warn_ticks  = idle_gap_warn_ticks;
    cfg.idle_gap_error_ticks = idle_gap_error_ticks;
    cfg.active = (irq_off_warn_ticks != '0) && (irq_off_error_ticks != '0) &&
                 (task_run_warn_ticks != '0) && (task_run_error_ticks != '0) &&
                 (idle_gap_warn_ticks != '0) && (idle_gap_error_ticks != '0);
  end

endmodule

`default_nettype wire

### src/rlw_core.sv
// Event register, state update and report register of the scheduler latency watchdog
`default_nettype none

module rlw_core #(
  parameter int TIME_BITS = rlw_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  rlw_pkg::rlw_cfg_t cfg,
  rlw_evt_if.sink          evt,
  rlw_rpt_if.source        rpt
);

  localparam int CW = (TIME_BITS > rlw_pkg::THRESH_W) ? TIME_BITS : rlw_pkg::THRESH_W;

  function automatic logic [rlw_pkg::RPT_W-1:0] grade(
    input logic [CW-1:0] d,
    input logic [CW-1:0] warn,
    input logic [CW-1:0] err
  );
    if (d > err) begin
      return rlw_pkg::RPT_ERROR;
    end else if (d > warn) begin
      return rlw_pkg::RPT_WARN;
    end
    return rlw_pkg::RPT_NONE;
  endfunction

  // event register
  logic                         s1_valid;
  logic                         s1_valid_next;
  logic [rlw_pkg::OP_W-1:0]     s1_op;
  logic [rlw_pkg::TS_W-1:0]     s1_ts;
  logic                         s1_idle;
  logic                         s1_caller;
  logic                         s1_restores;

  // report register
  logic                         o_valid;
  logic [rlw_pkg::RPT_W-1:0]    o_run;
  logic [rlw_pkg::RPT_W-1:0]    o_starve;
  logic [rlw_pkg::RPT_W-1:0]    o_irq;
  logic                         o_active;

  // monitor state
  logic [TIME_BITS-1:0]         task_begin_time, task_begin_time_next;
  logic [TIME_BITS-1:0]         idle_out_time, idle_out_time_next;
  logic [rlw_pkg::LEVEL_W-1:0]  starve_level, starve_level_next;
  logic [TIME_BITS-1:0]         irq_off_begin_time, irq_off_begin_time_next;
  logic [rlw_pkg::DEPTH_W-1:0]  irq_off_depth, irq_off_depth_next;
  logic                         irq_owner_valid, irq_owner_valid_next;

  logic                         accept;
  logic                         advance;
  logic                         fire;
  logic [TIME_BITS+rlw_pkg::TS_W-1:0] ts_ext;
  logic [TIME_BITS-1:0]         now;
  logic [TIME_BITS-1:0]         run_d;
  logic [TIME_BITS-1:0]         gap_d;
  logic [TIME_BITS-1:0]         irq_d;
  logic [CW-1:0]                gap_w;
  logic [rlw_pkg::DEPTH_W-1:0]  depth_dec;
  logic [rlw_pkg::RPT_W-1:0]    run_rep, starve_rep, irq_rep;

  assign advance   = !o_valid || rpt.ready;
  assign fire      = s1_valid && advance;
  assign evt.ready = !s1_valid || advance;
  assign accept    = evt.valid && evt.ready;

  assign s1_valid_next = accept ? 1'b1 : (fire ? 1'b0 : s1_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= evt.op;
      s1_ts       <= evt.timestamp;
      s1_idle     <= evt.is_idle;
      s1_caller   <= evt.caller_known;
      s1_restores <= evt.restores_enable;
    end
  end

  assign ts_ext    = {{TIME_BITS{1'b0}}, s1_ts};
  assign now       = ts_ext[TIME_BITS-1:0];
  assign run_d     = now - task_begin_time;
  assign gap_d     = now - idle_out_time;
  assign irq_d     = now - irq_off_begin_time;
  assign gap_w     = CW'(gap_d);
  assign depth_dec = irq_off_depth - rlw_pkg::DEPTH_W'(1);

  always_comb begin
    task_begin_time_next    = task_begin_time;
    idle_out_time_next      = idle_out_time;
    starve_level_next       = starve_level;
    irq_off_begin_time_next = irq_off_begin_time;
    irq_off_depth_next      = irq_off_depth;
    irq_owner_valid_next    = irq_owner_valid;
    run_rep                 = rlw_pkg::RPT_NONE;
    starve_rep              = rlw_pkg::RPT_NONE;
    irq_rep                 = rlw_pkg::RPT_NONE;
    case (s1_op)
      rlw_pkg::OP_INIT: begin
        task_begin_time_next    = '0;
        idle_out_time_next      = now;
        starve_level_next       = '0;
        irq_off_begin_time_next = '0;
        irq_off_depth_next      = '0;
        irq_owner_valid_next    = 1'b0;
      end
      rlw_pkg::OP_TASK_IN: begin
        if (cfg.active) begin
          if (s1_idle) begin
            starve_level_next    = '0;
            task_begin_time_next = '0;
          end else begin
            task_begin_time_next = now;
          end
        end
      end
      rlw_pkg::OP_TASK_OUT: begin
        if (cfg.active) begin
          task_begin_time_next = '0;
          if (s1_idle) begin
            idle_out_time_next = now;
            starve_level_next  = '0;
          end else begin
            if (task_begin_time != '0) begin
              run_rep = grade(CW'(run_d), CW'(cfg.task_run_warn_ticks),
                              CW'(cfg.task_run_error_ticks));
            end
            if (gap_w > CW'(cfg.idle_gap_error_ticks) &&
                starve_level < rlw_pkg::LEVEL_W'(rlw_pkg::RPT_ERROR)) begin
              starve_rep        = rlw_pkg::RPT_ERROR;
              starve_level_next = rlw_pkg::LEVEL_W'(rlw_pkg::RPT_ERROR);
            end else if (gap_w > CW'(cfg.idle_gap_warn_ticks) &&
                         starve_level < rlw_pkg::LEVEL_W'(rlw_pkg::RPT_WARN)) begin
              starve_rep        = rlw_pkg::RPT_WARN;
              starve_level_next = rlw_pkg::LEVEL_W'(rlw_pkg::RPT_WARN);
            end
          end
        end
      end
      rlw_pkg::OP_IRQ_BEGIN: begin
        if (cfg.active) begin
          if (irq_off_depth == '0) begin
            irq_off_begin_time_next = now;
            irq_owner_valid_next    = s1_caller;
          end
          irq_off_depth_next = irq_off_depth + rlw_pkg::DEPTH_W'(1);
        end
      end
      rlw_pkg::OP_IRQ_END: begin
        if (cfg.active && irq_off_depth != '0) begin
          if (!s1_restores) begin
            irq_off_depth_next = depth_dec;
            if (depth_dec == '0) begin
              irq_owner_valid_next = 1'b0;
            end
          end else begin
            irq_off_depth_next = '0;
            if (irq_owner_valid) begin
              irq_rep = grade(CW'(irq_d), CW'(cfg.irq_off_warn_ticks),
                              CW'(cfg.irq_off_error_ticks));
              irq_owner_valid_next = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_begin_time    <= '0;
      idle_out_time      <= '0;
      starve_level       <= '0;
      irq_off_begin_time <= '0;
      irq_off_depth      <= '0;
      irq_owner_valid    <= 1'b0;
    end else if (fire) begin
      task_begin_time    <= task_begin_time_next;
      idle_out_time      <= idle_out_time_next;
      starve_level       <= starve_level_next;
      irq_off_begin_time <= irq_off_begin_time_next;
      irq_off_depth      <= irq_off_depth_next;
      irq_owner_valid    <= irq_owner_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_run    <= run_rep;
      o_starve <= starve_rep;
      o_irq    <= irq_rep;
      o_active <= cfg.active;
    end
  end

  assign rpt.valid              = o_valid;
  assign rpt.task_run_report    = o_run;
  assign rpt.idle_starve_report = o_starve;
  assign rpt.irq_off_report     = o_irq;
  assign rpt.monitor_active     = o_active;

endmodule

`default_nettype wire

### src/rtos_latency_watchdog.sv
// Top level of the scheduler latency watchdog
`default_nettype none

// Scheduler latency watchdog. Takes timestamped scheduler events on evt and
// gives exactly one report transaction per event on rpt; each event passes the
// event register and then the report register. The sustained rate is one event
// per cycle while rpt is not stalled; the monitor state is updated combinationally
// between those two registers. A stalled report holds the event register, and
// evt.ready stays high while the event register is empty. Thresholds are written
// over APB at byte addresses 0, 4, .. 20 in the order irq-off warn/error,
// task-run warn/error, idle-gap warn/error; apart from init events, the monitor
// only acts while all six are nonzero. Write them only while no event is in flight.
module rtos_latency_watchdog #(
  parameter int TIME_BITS = rlw_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  rlw_evt_if.sink                             evt,
  rlw_rpt_if.source                           rpt,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rlw_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [rlw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [rlw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  rlw_pkg::rlw_cfg_t cfg;

  rlw_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlw_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .evt (evt),
    .rpt (rpt)
  );

`include "rtos_latency_watchdog_assert.svh"

  `RLW_ASSERT_HOLDS(a_ready_when_drained, !rpt.valid, evt.ready)
  `RLW_ASSERT_HOLDS(a_quiet_when_inactive, rpt.valid && !rpt.monitor_active,
    rpt.task_run_report == rlw_pkg::RPT_NONE && rpt.irq_off_report == rlw_pkg::RPT_NONE)
  `RLW_ASSERT_NEXT(a_cfg_write_lands,
    psel && penable && pwrite && pready &&
    paddr[rlw_pkg::CFG_ADDR_W-1:2] == rlw_pkg::REG_IRQ_OFF_WARN,
    cfg.irq_off_warn_ticks == $past(pwdata))

endmodule

`default_nettype wire
